/* rtl/psqe_pkg.sv */
// ----------------------------------------------------------------------------
// psqe_pkg - shared types and constants for the prime sieve query engine
// Holds the sequencer state encoding and the fixed field widths.
// ----------------------------------------------------------------------------
package psqe_pkg;

	// Fixed widths of the register and the data fields
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned QUERY_W = 16;
	localparam int unsigned COUNT_W = 16;

	// Smallest prime; the crossing-out pass starts here
	localparam int unsigned FIRST_PRIME = 2;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,  // waiting for a query
		ST_FILL   = 9'b000000010,  // initialise store 0..limit
		ST_PCHK   = 9'b000000100,  // test p*p against limit, read bit p
		ST_PRD    = 9'b000001000,  // bit p available
		ST_CROSS  = 9'b000010000,  // clear multiples of p
		ST_NEXTP  = 9'b000100000,  // advance p and p*p
		ST_COUNT  = 9'b001000000,  // count set bits 2..limit
		ST_LOOKUP = 9'b010000000,  // read bit of the query
		ST_RESP   = 9'b100000000   // present result
	} state_t;

endpackage

/* rtl/psqe_ram.sv */
// ----------------------------------------------------------------------------
// psqe_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psqe_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/psqe_alu.sv */
// ----------------------------------------------------------------------------
// psqe_alu - shared add and limit-compare unit
// Forms a + b + cin for the index and square updates, and flags a > limit.
// ----------------------------------------------------------------------------
module psqe_alu #(
	parameter int unsigned KW = 18,
	parameter int unsigned LW = 16
) (
	input  logic [KW-1:0] a,
	input  logic [KW-1:0] b,
	input  logic          cin,
	input  logic [LW-1:0] lim,
	output logic [KW-1:0] sum,
	output logic          a_gt_lim
);

	// Single adder shared by the index and square updates
	assign sum = a + b + KW'(cin);

	// Bound test against the effective limit
	assign a_gt_lim = (a > KW'(lim));

endmodule

/* rtl/prime_sieve_query_engine_core.sv */
// ----------------------------------------------------------------------------
// prime_sieve_query_engine_core - prime sieve with primality queries
// Builds a one-bit-per-number sieve over 0..limit in a RAM and answers
// queries with the stored bit and the count of primes up to the limit.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   cfg     | cfg_valid/cfg_ready | sieve_limit
//   in      | in_valid/in_stall   | query_number
//   out     | out_valid/out_stall | is_prime, out_of_range, prime_count
//
// Built sieve: the transfer cycle reads the bit RAM, the result loads in ST_RESP.
// Rebuild (first query after reset or a limit write): fill, then for each p with
// p*p <= limit a check, a read of bit p, crossing out its multiples if p is prime
// and an advance of p; then a closing check, the count of set bits and a lookup.
// Reset leaves the limit at 65535 and no sieve built. in_stall is high from a transfer
// until the result register loads; a stalled result holds, the next query is taken.
// ----------------------------------------------------------------------------
module prime_sieve_query_engine_core
	import psqe_pkg::*;
#(
	parameter int unsigned MAX_NUMBER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  sieve_limit,
	// query in
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [QUERY_W-1:0]  query_number,
	// result out
	output logic                out_valid,
	input  logic                out_stall,
	output logic                is_prime,
	output logic                out_of_range,
	output logic [COUNT_W-1:0]  prime_count
);

	localparam int unsigned NB    = MAX_NUMBER_BITS;
	localparam int unsigned DEPTH = 1 << NB;
	localparam int unsigned KW    = NB + 2;
	localparam int unsigned WW    = (NB > LIMIT_W) ? NB : LIMIT_W;
	localparam int unsigned TOP_INT = (1 << NB) - 1;
	localparam logic [WW-1:0] TOP = WW'(TOP_INT);

	state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic               ready_q;
	logic [QUERY_W-1:0] q_q;
	logic [KW-1:0]      k_q, p_q, sq_q;
	logic               pend_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [WW-1:0]      lim_ext, q_ext;
	logic [NB-1:0]      lim;
	logic               q_oor;

	logic [KW-1:0]      alu_a, alu_b, alu_sum;
	logic               alu_cin, alu_gt;

	logic               we;
	logic [NB-1:0]      waddr, raddr;
	logic               wdata, rdata;

	logic               in_xfer, out_free;

	// Effective limit, saturated to the store size
	assign lim_ext = (WW'(limit_q) > TOP) ? TOP : WW'(limit_q);
	assign lim     = lim_ext[NB-1:0];
	assign q_ext   = WW'(q_q);
	assign q_oor   = (q_ext > lim_ext);

	// Handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// Shared ALU operand selection
	always_comb begin
		alu_a   = k_q;
		alu_b   = '0;
		alu_cin = 1'b1;
		unique case (state_q)
			ST_PCHK:  alu_a = sq_q;
			ST_CROSS: begin
				alu_b   = p_q;
				alu_cin = 1'b0;
			end
			ST_NEXTP: begin
				alu_a = sq_q;
				alu_b = p_q << 1;
			end
			default: ;
		endcase
	end

	psqe_alu #(
		.KW (KW),
		.LW (NB)
	) u_alu (
		.a        (alu_a),
		.b        (alu_b),
		.cin      (alu_cin),
		.lim      (lim),
		.sum      (alu_sum),
		.a_gt_lim (alu_gt)
	);

	// Bit store access
	always_comb begin
		we    = 1'b0;
		waddr = k_q[NB-1:0];
		wdata = 1'b0;
		raddr = q_ext[NB-1:0];
		unique case (state_q)
			ST_IDLE:  raddr = NB'(query_number);
			ST_FILL:  begin
				we    = !alu_gt;
				wdata = (k_q >= KW'(FIRST_PRIME));
			end
			ST_PCHK:  raddr = p_q[NB-1:0];
			ST_CROSS: we = !alu_gt;
			ST_COUNT: raddr = k_q[NB-1:0];
			default: ;
		endcase
	end

	psqe_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_bits (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ready_q ? ST_RESP : ST_FILL;
				end
			end
			ST_FILL:   if (alu_gt) state_d = ST_PCHK;
			ST_PCHK:   state_d = alu_gt ? ST_COUNT : ST_PRD;
			ST_PRD:    state_d = rdata ? ST_CROSS : ST_NEXTP;
			ST_CROSS:  if (alu_gt) state_d = ST_NEXTP;
			ST_NEXTP:  state_d = ST_PCHK;
			ST_COUNT:  if (alu_gt && !pend_q) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_RESP;
			ST_RESP:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			limit_q   <= '1;
			ready_q   <= 1'b0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= sieve_limit;
				ready_q <= 1'b0;
			end else if (state_q == ST_COUNT && alu_gt && !pend_q) begin
				ready_q <= 1'b1;
			end
			// prime count, one bit read behind the index
			if (state_q == ST_PCHK && alu_gt) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_COUNT) begin
				if (pend_q && rdata) begin
					cnt_q <= cnt_q + COUNT_W'(1);
				end
				pend_q <= !alu_gt;
			end
			// result register
			if (state_q == ST_RESP && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			q_q <= query_number;
		end
		unique case (state_q)
			ST_IDLE: begin
				k_q  <= '0;
				p_q  <= KW'(FIRST_PRIME);
				sq_q <= KW'(FIRST_PRIME * FIRST_PRIME);
			end
			ST_FILL:  if (!alu_gt) k_q <= alu_sum;
			ST_PCHK:  if (alu_gt) k_q <= KW'(FIRST_PRIME);
			ST_PRD:   k_q <= sq_q;
			ST_CROSS: if (!alu_gt) k_q <= alu_sum;
			ST_NEXTP: begin
				sq_q <= alu_sum;
				p_q  <= p_q + KW'(1);
			end
			ST_COUNT: if (!alu_gt) k_q <= alu_sum;
			default: ;
		endcase
		if (state_q == ST_RESP && out_free) begin
			out_of_range <= q_oor;
			is_prime     <= !q_oor && rdata;
			prime_count  <= cnt_q;
		end
	end

endmodule
